// File: hdl/ptrs_pkg.sv
// Shared types and codes for the periodic task release scheduler.
package ptrs_pkg;

   localparam int CMD_W   = 3;
   localparam int SLOT_W  = 3;
   localparam int TICKS_W = 16;

   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd4;

   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] task_index;
      logic              create_error;
      logic              last;
   } rsp_item_type;

endpackage

// File: hdl/ptrs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ptrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // The read data holds while no read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/periodic_task_release_scheduler.sv
// Periodic task release scheduler: task slot table with tick-driven release stream.
//
// Commands arrive on the req_ stream: tick, create, suspend, resume and delete.
// Each slot keeps its delay and period in a small RAM; the occupied, running
// and written flags live in flip-flops. Suspend, resume and delete finish in
// the cycle of their transfer and give no result. A create gives one status
// transfer on the rsp_ stream by way of the holding stage, and holds
// req_tready low while that result waits in the holding stage.
// A tick walks the slots in index order, one RAM read per slot, and writes
// each running slot back once its read data is registered, so a tick holds
// req_tready low until the walk is done and its last release has left the
// holding stage. Each release found goes to the rsp_ stream; the final
// result of a command has rsp_tlast set. Results pass through a holding
// stage and an output register, so a stalled receiver only halts the walk
// when a third result is waiting.
// A new command is taken once the holding stage is empty.
// Reset clears all slot flags, so every slot reads as free with zero delay
// and zero period; no clearing pass over the RAM is needed.
module periodic_task_release_scheduler #(
   parameter int TASK_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // slot_index[2:0], period_ticks[18:3], initial_delay[34:19]
   input  logic [2:0]  req_tuser,  // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // task_index[2:0], create_error[3]
   output logic [0:0]  rsp_tuser,  // result_kind[0]
   output logic        rsp_tlast
);

   localparam int IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
   localparam int WIDE_W = IDX_W + ptrs_pkg::SLOT_W;
   localparam int DATA_W = 2 * ptrs_pkg::TICKS_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                          state_ff, state_in;
   logic [CNT_W-1:0]              next_ff, next_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]              rd_slot_ff, rd_slot_in;
   logic [TASK_SLOTS-1:0]         occ_ff, occ_in;
   logic [TASK_SLOTS-1:0]         run_ff, run_in;
   logic [TASK_SLOTS-1:0]         wrt_ff, wrt_in;
   logic                          pend_valid_ff, pend_valid_in;
   ptrs_pkg::rsp_item_type        pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ptrs_pkg::rsp_item_type        rsp_ff, rsp_in;

   logic                          ram_we;
   logic [IDX_W-1:0]              ram_waddr;
   logic [DATA_W-1:0]             ram_wdata;
   logic                          ram_re;
   logic [IDX_W-1:0]              ram_raddr;
   logic [DATA_W-1:0]             ram_q;

   logic [ptrs_pkg::CMD_W-1:0]    req_cmd;
   logic [ptrs_pkg::SLOT_W-1:0]   req_slot;
   logic [ptrs_pkg::TICKS_W-1:0]  req_period;
   logic [ptrs_pkg::TICKS_W-1:0]  req_delay;
   logic [WIDE_W-1:0]             slot_wide;
   logic [IDX_W-1:0]              slot_addr;
   logic                          slot_ok;
   logic                          req_fire;

   logic [DATA_W-1:0]             cur_data;
   logic [ptrs_pkg::TICKS_W-1:0]  cur_delay;
   logic [ptrs_pkg::TICKS_W-1:0]  cur_period;
   logic [ptrs_pkg::TICKS_W-1:0]  cur_new_delay;
   logic                          cur_run;
   logic                          cur_rel;
   logic [WIDE_W-1:0]             cur_idx_wide;
   logic                          out_free;
   logic                          stall;

   assign req_cmd    = req_tuser;
   assign req_slot   = req_tdata[2:0];
   assign req_period = req_tdata[18:3];
   assign req_delay  = req_tdata[34:19];

   assign slot_wide = {{IDX_W{1'b0}}, req_slot};
   assign slot_addr = slot_wide[IDX_W-1:0];
   assign slot_ok   = slot_wide < WIDE_W'(TASK_SLOTS);

   assign req_tready = (state_ff == ST_IDLE) && !pend_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   // Entries never written since reset read as zero delay and zero period.
   assign cur_data      = wrt_ff[rd_slot_ff] ? ram_q : '0;
   assign cur_delay     = cur_data[ptrs_pkg::TICKS_W-1:0];
   assign cur_period    = cur_data[DATA_W-1:ptrs_pkg::TICKS_W];
   assign cur_new_delay = (cur_delay != '0) ? cur_delay - 1'b1 : cur_period - 1'b1;
   assign cur_run       = run_ff[rd_slot_ff];
   assign cur_rel       = cur_run && occ_ff[rd_slot_ff] && (cur_delay == '0);
   assign cur_idx_wide  = {{ptrs_pkg::SLOT_W{1'b0}}, rd_slot_ff};

   assign out_free = !rsp_valid_ff || rsp_tready;
   // A new release needs the holding stage, which only frees when the output can take it.
   assign stall    = rd_valid_ff && cur_rel && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      next_in       = next_ff;
      rd_valid_in   = rd_valid_ff;
      rd_slot_in    = rd_slot_ff;
      occ_in        = occ_ff;
      run_in        = run_ff;
      wrt_in        = wrt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_addr;
      ram_wdata     = {req_period, req_delay};
      ram_re        = 1'b0;
      ram_raddr     = next_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // The held result moves on once it is known to be final or a newer one replaces it.
      if (pend_valid_ff && out_free &&
          (pend_ff.last || (rd_valid_ff && cur_rel))) begin
         rsp_in        = pend_ff;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  ptrs_pkg::CMD_TICK: begin
                     state_in    = ST_WALK;
                     next_in     = '0;
                     rd_valid_in = 1'b0;
                  end
                  ptrs_pkg::CMD_CREATE: begin
                     pend_valid_in        = 1'b1;
                     pend_in.kind         = ptrs_pkg::KIND_STATUS;
                     pend_in.task_index   = req_slot;
                     pend_in.last         = 1'b1;
                     if (slot_ok && !occ_ff[slot_addr]) begin
                        pend_in.create_error = 1'b0;
                        ram_we               = 1'b1;
                        occ_in[slot_addr]    = 1'b1;
                        run_in[slot_addr]    = 1'b1;
                        wrt_in[slot_addr]    = 1'b1;
                     end else begin
                        pend_in.create_error = 1'b1;
                     end
                  end
                  ptrs_pkg::CMD_SUSPEND: begin
                     if (slot_ok) begin
                        run_in[slot_addr] = 1'b0;
                     end
                  end
                  ptrs_pkg::CMD_RESUME: begin
                     if (slot_ok) begin
                        run_in[slot_addr] = 1'b1;
                     end
                  end
                  ptrs_pkg::CMD_DELETE: begin
                     if (slot_ok) begin
                        occ_in[slot_addr] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!stall) begin
               if (rd_valid_ff && cur_run) begin
                  ram_we             = 1'b1;
                  ram_waddr          = rd_slot_ff;
                  ram_wdata          = {cur_period, cur_new_delay};
                  wrt_in[rd_slot_ff] = 1'b1;
               end
               if (rd_valid_ff && cur_rel) begin
                  pend_valid_in        = 1'b1;
                  pend_in.kind         = ptrs_pkg::KIND_RELEASE;
                  pend_in.task_index   = cur_idx_wide[ptrs_pkg::SLOT_W-1:0];
                  pend_in.create_error = 1'b0;
                  pend_in.last         = 1'b0;
               end
               if (next_ff < CNT_W'(TASK_SLOTS)) begin
                  ram_re      = 1'b1;
                  rd_valid_in = 1'b1;
                  rd_slot_in  = next_ff[IDX_W-1:0];
                  next_in     = next_ff + 1'b1;
               end else begin
                  rd_valid_in = 1'b0;
                  if (!rd_valid_ff) begin
                     // Walk finished: whatever release is held is the final one.
                     state_in     = ST_IDLE;
                     pend_in.last = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         occ_ff        <= '0;
         run_ff        <= '0;
         wrt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         occ_ff        <= occ_in;
         run_ff        <= run_in;
         wrt_ff        <= wrt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      next_ff    <= next_in;
      rd_slot_ff <= rd_slot_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   ptrs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TASK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.create_error, rsp_ff.task_index};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule
